/* src/assert_macros.svh */
// Assertion macros shared by the ring logger RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/psrl_pkg.sv */
// Shared codes and types for the pooled sample ring logger.
// No dependencies.
package psrl_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_RESET = 2'd3
  } psrl_op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_WRITE = 2'd1;
  localparam logic [1:0] ST_NO_READ  = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } psrl_fifo_ctl_t;

endpackage

/* src/psrl_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module psrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/psrl_fifo.sv */
// Ring-index FIFO with head and next-to-head views.
// Depends on psrl_pkg and assert_macros.svh.
`include "assert_macros.svh"
module psrl_fifo import psrl_pkg::*; #(
  parameter int DEPTH     = 8,
  parameter int RING_BITS = 3,
  parameter bit INIT_FULL = 1'b0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  psrl_fifo_ctl_t             ctl,
  input  logic [RING_BITS-1:0]       push_ring,
  output logic [RING_BITS-1:0]       head_ring,
  output logic [RING_BITS-1:0]       next_ring,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [RING_BITS-1:0] slot_r [DEPTH];
  logic [PW-1:0]        head_r;
  logic [CW-1:0]        count_r;
  logic [PW:0]          tail_sum;
  logic [PW-1:0]        tail_idx;
  logic [PW-1:0]        head_inc;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    tail_sum = {1'b0, head_r} + (PW+1)'(count_r);
    if (tail_sum >= (PW+1)'(DEPTH)) begin
      tail_sum = tail_sum - (PW+1)'(DEPTH);
    end
    tail_idx = tail_sum[PW-1:0];
    if ({1'b0, head_r} == (PW+1)'(DEPTH - 1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_r + PW'(1);
    end
    do_push = ctl.push && (count_r != CW'(DEPTH));
    do_pop  = ctl.pop && (count_r != '0);
  end

  assign head_ring = slot_r[head_r];
  assign next_ring = slot_r[head_inc];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        slot_r[i] <= RING_BITS'(i + 1);
      end
      count_r <= INIT_FULL ? CW'(DEPTH - 1) : '0;
    end else begin
      if (do_push) begin
        slot_r[tail_idx] <= push_ring;
      end
      if (do_pop) begin
        head_r <= head_inc;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  `ASSERT_CLK(a_fifo_no_overfill, count_r <= CW'(DEPTH), "ring FIFO count beyond depth")
  `ASSERT_CLK(a_fifo_pop_nonempty, ctl.pop |-> count_r != '0, "pop from empty ring FIFO")

endmodule

/* src/pooled_sample_ring_logger.sv */
// Top level of the pooled sample ring logger: sequencer, ring FIFOs and RAMs.
// Depends on psrl_pkg, psrl_ram, psrl_fifo and assert_macros.svh.
//
// A command beat is taken when start is high and busy is low; its single result
// appears on the out_ ports for exactly one cycle with out_valid high, and the
// receiver cannot stall it, so capture it on that cycle. One command is worked
// at a time. A write or a flush acts on the writer ring; a read fetches the
// head reader ring's metadata and then one sample RAM entry, returning each
// exhausted ring to the pool on the way; a pool reset returns the writer and
// every reader ring to the pool and takes a fresh writer. Each command then
// checks data availability through the ring metadata RAM, which the sequencer
// reads one entry per step with registered read data. Samples live in
// one RAM of RING_TOTAL*RING_DEPTH entries; per-ring position and limit live
// in a small metadata RAM with register-held valid bits, so a ring in the
// free pool reads as position zero and full length without any clearing pass.
`include "assert_macros.svh"
module pooled_sample_ring_logger import psrl_pkg::*; #(
  parameter int RING_TOTAL  = 8,
  parameter int RING_DEPTH  = 64,
  parameter int SAMPLE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_sample_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_data,
  output logic        out_read_valid,
  output logic        out_data_available
);

  localparam int RB  = $clog2(RING_TOTAL);
  localparam int PB  = $clog2(RING_DEPTH + 1);
  localparam int CB  = $clog2(RING_TOTAL + 1);
  localparam int SD  = RING_TOTAL * RING_DEPTH;
  localparam int SAW = $clog2(SD);
  localparam int MW  = 2 * PB;

  // Sequencer states, one-hot.
  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_WRITE    = 13'b0000000000010,
    S_FLUSH    = 13'b0000000000100,
    S_RESET    = 13'b0000000001000,
    S_RST_LOOP = 13'b0000000010000,
    S_RST_TAKE = 13'b0000000100000,
    S_RD_REQ   = 13'b0000001000000,
    S_RD_CHK   = 13'b0000010000000,
    S_RD_DAT   = 13'b0000100000000,
    S_AV_REQ   = 13'b0001000000000,
    S_AV_CHK1  = 13'b0010000000000,
    S_AV_CHK2  = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Writer ring; its position stays in a register while it is the writer.
  logic [RB-1:0] writer_r, writer_nxt;
  logic          present_r, present_nxt;
  logic [PB-1:0] wr_pos_r, wr_pos_nxt;

  // Result registers.
  logic [1:0]             status_r, status_nxt;
  logic [SAMPLE_BITS-1:0] rdata_r, rdata_nxt;
  logic                   rvalid_r, rvalid_nxt;
  logic                   avail_r, avail_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;

  // Metadata valid bits: clear means position zero, full length.
  logic [RING_TOTAL-1:0] meta_vld_r, meta_vld_nxt;
  logic                  vld_q_r;

  // Free and reader FIFOs.
  psrl_fifo_ctl_t free_ctl, rdr_ctl;
  logic [RB-1:0]  free_push, free_head, free_next;
  logic [RB-1:0]  rdr_head, rdr_next;
  logic [CB-1:0]  free_cnt, rdr_cnt;

  // RAM ports.
  logic           meta_we, meta_re;
  logic [RB-1:0]  meta_waddr, meta_raddr;
  logic [MW-1:0]  meta_wdata, meta_q;
  logic [PB-1:0]  mq_pos, mq_lim;
  logic           smp_we, smp_re;
  logic [SAW-1:0] smp_waddr, smp_raddr;
  logic [SAMPLE_BITS-1:0] smp_q;

  logic [63:0] rdata_ext;

  psrl_fifo #(.DEPTH(RING_TOTAL), .RING_BITS(RB), .INIT_FULL(1'b1)) u_free_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (free_ctl),
    .push_ring (free_push),
    .head_ring (free_head),
    .next_ring (free_next),
    .count     (free_cnt)
  );

  psrl_fifo #(.DEPTH(RING_TOTAL), .RING_BITS(RB), .INIT_FULL(1'b0)) u_rdr_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rdr_ctl),
    .push_ring (writer_r),
    .head_ring (rdr_head),
    .next_ring (rdr_next),
    .count     (rdr_cnt)
  );

  psrl_ram #(.WIDTH(MW), .DEPTH(RING_TOTAL)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_q)
  );

  psrl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(SD)) u_sample_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (sample_r),
    .re    (smp_re),
    .raddr (smp_raddr),
    .rdata (smp_q)
  );

  // Decode metadata read data; an entry without its valid bit is a fresh ring.
  always_comb begin
    mq_pos = vld_q_r ? meta_q[MW-1:PB] : '0;
    mq_lim = vld_q_r ? meta_q[PB-1:0] : PB'(RING_DEPTH);
  end

  always_comb begin
    state_nxt    = state_r;
    writer_nxt   = writer_r;
    present_nxt  = present_r;
    wr_pos_nxt   = wr_pos_r;
    status_nxt   = status_r;
    rdata_nxt    = rdata_r;
    rvalid_nxt   = rvalid_r;
    avail_nxt    = avail_r;
    meta_vld_nxt = meta_vld_r;
    free_ctl     = '0;
    rdr_ctl      = '0;
    free_push    = writer_r;
    meta_we      = 1'b0;
    meta_waddr   = writer_r;
    meta_wdata   = {PB'(0), PB'(RING_DEPTH)};
    meta_re      = 1'b0;
    meta_raddr   = rdr_head;
    smp_we       = 1'b0;
    smp_waddr    = SAW'(writer_r) * SAW'(RING_DEPTH) + SAW'(wr_pos_r);
    smp_re       = 1'b0;
    smp_raddr    = SAW'(rdr_head) * SAW'(RING_DEPTH) + SAW'(mq_pos);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = ST_OK;
          rdata_nxt  = '0;
          rvalid_nxt = 1'b0;
          case (psrl_op_t'(in_op))
            OP_WRITE: state_nxt = S_WRITE;
            OP_READ:  state_nxt = S_RD_REQ;
            OP_FLUSH: state_nxt = S_FLUSH;
            OP_RESET: state_nxt = S_RESET;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        state_nxt = S_AV_REQ;
        if (!present_r) begin
          status_nxt = ST_NO_WRITE;
        end else if (wr_pos_r == PB'(RING_DEPTH)) begin
          // Hand the full ring to the readers, then pull a fresh one.
          meta_we                = 1'b1;
          meta_vld_nxt[writer_r] = 1'b1;
          rdr_ctl.push           = 1'b1;
          if (free_cnt == '0) begin
            present_nxt = 1'b0;
            status_nxt  = ST_NO_WRITE;
          end else begin
            free_ctl.pop = 1'b1;
            writer_nxt   = free_head;
            smp_we       = 1'b1;
            smp_waddr    = SAW'(free_head) * SAW'(RING_DEPTH);
            wr_pos_nxt   = PB'(1);
          end
        end else begin
          smp_we     = 1'b1;
          wr_pos_nxt = wr_pos_r + PB'(1);
        end
      end
      S_FLUSH: begin
        state_nxt = S_AV_REQ;
        if (present_r) begin
          // Cut the writer to its fill and queue it for reading.
          meta_we                = 1'b1;
          meta_wdata             = {PB'(0), wr_pos_r};
          meta_vld_nxt[writer_r] = 1'b1;
          rdr_ctl.push           = 1'b1;
          if (free_cnt == '0) begin
            present_nxt = 1'b0;
          end else begin
            free_ctl.pop = 1'b1;
            writer_nxt   = free_head;
            wr_pos_nxt   = '0;
          end
        end
      end
      S_RESET: begin
        state_nxt = S_RST_LOOP;
        if (present_r) begin
          free_ctl.push = 1'b1;
          present_nxt   = 1'b0;
        end
      end
      S_RST_LOOP: begin
        // Drain one reader ring per cycle into the free pool.
        if (rdr_cnt != '0) begin
          rdr_ctl.pop   = 1'b1;
          free_ctl.push = 1'b1;
          free_push     = rdr_head;
        end else begin
          state_nxt = S_RST_TAKE;
        end
      end
      S_RST_TAKE: begin
        meta_vld_nxt = '0;
        state_nxt    = S_AV_REQ;
        if (free_cnt != '0) begin
          free_ctl.pop = 1'b1;
          writer_nxt   = free_head;
          present_nxt  = 1'b1;
          wr_pos_nxt   = '0;
        end
      end
      S_RD_REQ: begin
        if (rdr_cnt == '0) begin
          status_nxt = ST_NO_READ;
          state_nxt  = S_AV_REQ;
        end else begin
          meta_re   = 1'b1;
          state_nxt = S_RD_CHK;
        end
      end
      S_RD_CHK: begin
        if (mq_pos < mq_lim) begin
          smp_re     = 1'b1;
          meta_we    = 1'b1;
          meta_waddr = rdr_head;
          meta_wdata = {mq_pos + PB'(1), mq_lim};
          state_nxt  = S_RD_DAT;
        end else begin
          // Return the exhausted ring to the pool and retry.
          rdr_ctl.pop            = 1'b1;
          free_ctl.push          = 1'b1;
          free_push              = rdr_head;
          meta_vld_nxt[rdr_head] = 1'b0;
          state_nxt              = S_RD_REQ;
        end
      end
      S_RD_DAT: begin
        rdata_nxt  = smp_q;
        rvalid_nxt = 1'b1;
        status_nxt = ST_OK;
        state_nxt  = S_AV_REQ;
      end
      S_AV_REQ: begin
        if (rdr_cnt == '0) begin
          avail_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          meta_re   = 1'b1;
          state_nxt = S_AV_CHK1;
        end
      end
      S_AV_CHK1: begin
        if (mq_pos < mq_lim) begin
          avail_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (rdr_cnt < CB'(2)) begin
          avail_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          meta_re    = 1'b1;
          meta_raddr = rdr_next;
          state_nxt  = S_AV_CHK2;
        end
      end
      S_AV_CHK2: begin
        avail_nxt = mq_pos < mq_lim;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      writer_r   <= '0;
      present_r  <= 1'b1;
      wr_pos_r   <= '0;
      meta_vld_r <= '0;
      status_r   <= ST_OK;
      rvalid_r   <= 1'b0;
      avail_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      writer_r   <= writer_nxt;
      present_r  <= present_nxt;
      wr_pos_r   <= wr_pos_nxt;
      meta_vld_r <= meta_vld_nxt;
      status_r   <= status_nxt;
      rvalid_r   <= rvalid_nxt;
      avail_r    <= avail_nxt;
    end
  end

  // Payload registers: hold the sample of the accepted beat and the read data.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      sample_r <= in_sample_data[SAMPLE_BITS-1:0];
    end
    if (meta_re) begin
      vld_q_r <= meta_vld_r[meta_raddr];
    end
    rdata_r <= rdata_nxt;
  end

  always_comb begin
    rdata_ext                  = '0;
    rdata_ext[SAMPLE_BITS-1:0] = rdata_r;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_DONE);
  assign out_status         = status_r;
  assign out_read_data      = rdata_ext;
  assign out_read_valid     = rvalid_r;
  assign out_data_available = avail_r;

  `ASSERT_CLK(a_one_cycle_result, out_valid |=> !out_valid, "result strobe held over two cycles")
  `ASSERT_CLK(a_read_valid_ok, out_valid && out_read_valid |-> out_status == ST_OK, "read data with error status")
  `ASSERT_CLK(a_accept_goes_busy, start && !busy |=> busy, "accepted beat did not start work")
  `ASSERT_CLK(a_no_meta_rw_clash, meta_we && meta_re |-> meta_waddr != meta_raddr, "metadata read and write collide")
  `ASSERT_CLK(a_free_distinct, free_cnt >= CB'(2) |-> free_next != free_head, "free pool holds a ring twice")

endmodule
